// ----- sv/pnrf_pkg.sv -----
package pnrf_pkg;

    // operation field codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_FILL  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // what the back end has to do with a queued item
    typedef enum logic [1:0] {
        JOB_CLEAR = 2'd0,
        JOB_FILL  = 2'd1,
        JOB_READ  = 2'd2,
        JOB_NOP   = 2'd3
    } t_job_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_ROW,
        ST_BYTE,
        ST_MERGE,
        ST_READ,
        ST_DONE
    } t_back_state;

    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
    localparam int         NIBBLE_W    = 4;

endpackage

// ----- sv/pnrf_in_if.sv -----
interface pnrf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic [3:0]         fill_color;
    logic [16:0]        byte_address;

    modport source (
        output valid, operation, rect_x, rect_y, rect_width, rect_height,
               fill_color, byte_address,
        input  ready
    );
    modport sink (
        input  valid, operation, rect_x, rect_y, rect_width, rect_height,
               fill_color, byte_address,
        output ready
    );
endinterface

// ----- sv/pnrf_out_if.sv -----
interface pnrf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       drawn;

    modport source (output valid, read_data, drawn, input ready);
    modport sink (input valid, read_data, drawn, output ready);
endinterface

// ----- sv/pnrf_ram.sv -----
module pnrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                   i_wdata,
    input  logic                               i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                   o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/pnrf_front.sv -----
module pnrf_front #(
    parameter int  SCREEN_WIDTH  = 480,
    parameter int  SCREEN_HEIGHT = 320,
    parameter type t_job         = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnrf_in_if.sink     i_in,
    input  logic        i_busy,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);
    localparam int NPIX        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int STORE_BYTES = (NPIX + 1) / 2;
    localparam int AW          = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;
    localparam int CW          = $clog2(SCREEN_WIDTH + 1);
    localparam int RW          = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW          = $clog2(NPIX);
    localparam logic signed [17:0] W_S = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] H_S = 18'(SCREEN_HEIGHT);

    // clamp a signed coordinate into [0, lim]
    function automatic logic [17:0] clamp(input logic signed [17:0] v,
                                          input logic signed [17:0] lim);
        logic [17:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic signed [17:0] x_s, y_s, w_s, h_s, xe_s, ye_s;
    logic               accept;
    logic               advance;

    logic               r_a_valid;
    pnrf_pkg::t_op      r_a_op;
    logic [3:0]         r_a_color;
    logic [CW-1:0]      r_a_left, r_a_right;
    logic [RW-1:0]      r_a_top, r_a_bot;
    logic               r_a_pos;
    logic               r_a_addr_ok;
    logic [AW-1:0]      r_a_addr;

    logic [PW-1:0]      top_ext;

    always_comb begin
        x_s  = {{2{i_in.rect_x[15]}}, i_in.rect_x};
        y_s  = {{2{i_in.rect_y[15]}}, i_in.rect_y};
        w_s  = {{2{i_in.rect_width[15]}}, i_in.rect_width};
        h_s  = {{2{i_in.rect_height[15]}}, i_in.rect_height};
        xe_s = x_s + w_s;
        ye_s = y_s + h_s;
    end

    assign o_push     = r_a_valid && !i_q_full;
    assign advance    = !r_a_valid || o_push;
    assign i_in.ready = advance && !i_busy;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= accept;
        end
        if (accept) begin
            r_a_op      <= pnrf_pkg::t_op'(i_in.operation);
            r_a_color   <= i_in.fill_color;
            r_a_left    <= CW'(clamp(x_s, W_S));
            r_a_right   <= CW'(clamp(xe_s, W_S));
            r_a_top     <= RW'(clamp(y_s, H_S));
            r_a_bot     <= RW'(clamp(ye_s, H_S));
            r_a_pos     <= (w_s > 0) && (h_s > 0);
            r_a_addr_ok <= 32'(i_in.byte_address) < 32'(STORE_BYTES);
            r_a_addr    <= AW'(i_in.byte_address);
        end
    end

    // classify; the row base multiply is registered in the queue
    assign top_ext = PW'(r_a_top);

    always_comb begin
        o_job       = '0;
        o_job.color = r_a_color;
        o_job.left  = r_a_left;
        o_job.right = r_a_right;
        o_job.rows  = r_a_bot - r_a_top;
        o_job.base  = PW'(top_ext * PW'(SCREEN_WIDTH));
        o_job.addr  = r_a_addr;
        unique case (r_a_op)
            pnrf_pkg::OP_CLEAR: o_job.kind = pnrf_pkg::JOB_CLEAR;
            pnrf_pkg::OP_FILL: begin
                if (r_a_pos && (r_a_left < r_a_right) && (r_a_top < r_a_bot)) begin
                    o_job.kind = pnrf_pkg::JOB_FILL;
                end else begin
                    o_job.kind = pnrf_pkg::JOB_NOP;
                end
            end
            pnrf_pkg::OP_READ: begin
                o_job.kind = r_a_addr_ok ? pnrf_pkg::JOB_READ : pnrf_pkg::JOB_NOP;
            end
            default: o_job.kind = pnrf_pkg::JOB_NOP;
        endcase
    end
endmodule

// ----- sv/pnrf_queue.sv -----
module pnrf_queue #(
    parameter int  DEPTH = 2,
    parameter type t_job = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wdata,
    output logic o_full,
    input  logic i_pop,
    output t_job o_rdata,
    output logic o_empty
);
    localparam int IW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [IW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    assign o_full  = r_count == NW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == IW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == IW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end
endmodule

// ----- sv/pnrf_back.sv -----
module pnrf_back #(
    parameter int  SCREEN_WIDTH  = 480,
    parameter int  SCREEN_HEIGHT = 320,
    parameter type t_job         = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_q_head,
    output logic        o_pop,
    output logic        o_busy,
    pnrf_out_if.source  o_out
);
    localparam int NPIX        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int STORE_BYTES = (NPIX + 1) / 2;
    localparam int AW          = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;
    localparam int RW          = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW          = $clog2(NPIX);
    localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);

    pnrf_pkg::t_back_state r_state, n_state;
    t_job                  r_job;
    logic [AW-1:0]         r_byte;
    logic [AW-1:0]         r_first, r_last;
    logic                  r_s_odd, r_e_even;
    logic [PW-1:0]         r_row_base;
    logic [RW-1:0]         r_rows;
    logic                  r_res_valid;
    logic [7:0]            r_res_data;
    logic                  r_res_drawn;

    logic [31:0] p_start, p_end;
    logic        hi_cov, lo_cov, whole, at_last, last_row, slot_free;
    logic [7:0]  color_byte;

    logic            ram_we, ram_re, load_res;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;

    pnrf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign p_start    = 32'(r_row_base) + 32'(r_job.left);
    assign p_end      = 32'(r_row_base) + 32'(r_job.right) - 32'd1;
    assign hi_cov     = !((r_byte == r_first) && r_s_odd);
    assign lo_cov     = !((r_byte == r_last) && r_e_even);
    assign whole      = hi_cov && lo_cov;
    assign at_last    = r_byte == r_last;
    assign last_row   = r_rows == RW'(1);
    assign slot_free  = !r_res_valid || o_out.ready;
    assign color_byte = {r_job.color, r_job.color};
    assign o_busy     = r_state == pnrf_pkg::ST_INIT;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pnrf_pkg::ST_INIT: begin
                if (r_byte == LAST_BYTE) n_state = pnrf_pkg::ST_IDLE;
            end
            pnrf_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_head.kind)
                        pnrf_pkg::JOB_CLEAR: n_state = pnrf_pkg::ST_SWEEP;
                        pnrf_pkg::JOB_FILL:  n_state = pnrf_pkg::ST_ROW;
                        pnrf_pkg::JOB_READ:  n_state = pnrf_pkg::ST_READ;
                        default:             n_state = pnrf_pkg::ST_DONE;
                    endcase
                end
            end
            pnrf_pkg::ST_SWEEP: begin
                if (r_byte == LAST_BYTE) n_state = pnrf_pkg::ST_DONE;
            end
            pnrf_pkg::ST_ROW: n_state = pnrf_pkg::ST_BYTE;
            pnrf_pkg::ST_BYTE: begin
                if (!whole) begin
                    n_state = pnrf_pkg::ST_MERGE;
                end else if (at_last) begin
                    n_state = last_row ? pnrf_pkg::ST_DONE : pnrf_pkg::ST_ROW;
                end
            end
            pnrf_pkg::ST_MERGE: begin
                if (at_last) begin
                    n_state = last_row ? pnrf_pkg::ST_DONE : pnrf_pkg::ST_ROW;
                end else begin
                    n_state = pnrf_pkg::ST_BYTE;
                end
            end
            pnrf_pkg::ST_READ: n_state = pnrf_pkg::ST_DONE;
            pnrf_pkg::ST_DONE: begin
                if (slot_free) n_state = pnrf_pkg::ST_IDLE;
            end
            default: n_state = pnrf_pkg::ST_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_byte;
        ram_raddr = r_byte;
        ram_wdata = color_byte;
        o_pop     = 1'b0;
        load_res  = 1'b0;
        unique case (r_state)
            pnrf_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            pnrf_pkg::ST_IDLE:  o_pop = !i_q_empty;
            pnrf_pkg::ST_SWEEP: ram_we = 1'b1;
            pnrf_pkg::ST_BYTE: begin
                ram_we = whole;
                ram_re = !whole;
            end
            pnrf_pkg::ST_MERGE: begin
                ram_we = 1'b1;
                if (hi_cov) begin
                    ram_wdata = (ram_rdata & pnrf_pkg::LOW_NIBBLE) |
                                (8'(r_job.color) << pnrf_pkg::NIBBLE_W);
                end else begin
                    ram_wdata = (ram_rdata & pnrf_pkg::HIGH_NIBBLE) | 8'(r_job.color);
                end
            end
            pnrf_pkg::ST_READ: begin
                ram_re    = 1'b1;
                ram_raddr = r_job.addr;
            end
            pnrf_pkg::ST_DONE: load_res = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pnrf_pkg::ST_INIT;
            r_byte      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_res) begin
                r_res_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_res_valid <= 1'b0;
            end
            priority if (o_pop) begin
                r_byte <= '0;
            end else if (r_state == pnrf_pkg::ST_INIT || r_state == pnrf_pkg::ST_SWEEP) begin
                r_byte <= r_byte + 1'b1;
            end else if (r_state == pnrf_pkg::ST_ROW) begin
                r_byte <= AW'(p_start >> 1);
            end else if ((r_state == pnrf_pkg::ST_BYTE && whole) ||
                         r_state == pnrf_pkg::ST_MERGE) begin
                if (!at_last) r_byte <= r_byte + 1'b1;
            end
        end

        if (o_pop) begin
            r_job      <= i_q_head;
            r_row_base <= i_q_head.base;
            r_rows     <= i_q_head.rows;
        end
        if (r_state == pnrf_pkg::ST_ROW) begin
            r_first  <= AW'(p_start >> 1);
            r_last   <= AW'(p_end >> 1);
            r_s_odd  <= p_start[0];
            r_e_even <= !p_end[0];
        end
        if (((r_state == pnrf_pkg::ST_BYTE && whole) || r_state == pnrf_pkg::ST_MERGE)
            && at_last) begin
            r_rows     <= r_rows - 1'b1;
            r_row_base <= r_row_base + PW'(SCREEN_WIDTH);
        end
        if (load_res) begin
            r_res_data  <= (r_job.kind == pnrf_pkg::JOB_READ) ? ram_rdata : 8'd0;
            r_res_drawn <= (r_job.kind == pnrf_pkg::JOB_CLEAR) ||
                           (r_job.kind == pnrf_pkg::JOB_FILL);
        end
    end

    assign o_out.valid     = r_res_valid;
    assign o_out.read_data = r_res_data;
    assign o_out.drawn     = r_res_drawn;
endmodule

// ----- sv/packed_nibble_rect_fill.sv -----
// channel   dir  handshake      payload
// i_in      in   valid/ready    operation, rect_x/y, rect_width/height, fill_color,
//                               byte_address
// o_out     out  valid/ready    read_data, drawn
//
// One result item per input item. Front: one register stage clips the rectangle,
// then a two-entry queue feeds the back end sequencer, which owns the pixel RAM
// (one write and one registered read port, one byte per cycle).
// Read: front register, queue, back end RAM read, registered result; a no-op skips the
// read. Fill: per covered row a setup state, a write per whole byte and a read then merge
// per half-covered edge byte. Clear: all (W*H+1)/2 bytes, one byte per cycle through the
// RAM write port. Reset: synchronous; afterwards a zeroing pass over all bytes runs with
// i_in.ready low. A stalled output keeps one result; the queue accepts until it is full.
module packed_nibble_rect_fill #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnrf_in_if.sink     i_in,
    pnrf_out_if.source  o_out
);
    localparam int NPIX        = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int STORE_BYTES = (NPIX + 1) / 2;
    localparam int AW          = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;
    localparam int CW          = $clog2(SCREEN_WIDTH + 1);
    localparam int RW          = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW          = $clog2(NPIX);
    localparam int Q_DEPTH     = 2;

    // one classified item: clipped columns (right is exclusive), row count,
    // pixel index of the first row's column 0, read address
    typedef struct packed {
        pnrf_pkg::t_job_kind kind;
        logic [3:0]          color;
        logic [CW-1:0]       left;
        logic [CW-1:0]       right;
        logic [RW-1:0]       rows;
        logic [PW-1:0]       base;
        logic [AW-1:0]       addr;
    } t_job;

    t_job w_push_job, w_head_job;
    logic w_push, w_q_full, w_pop, w_q_empty, w_busy;

    pnrf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .t_job         (t_job)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_busy   (w_busy),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    pnrf_queue #(
        .DEPTH (Q_DEPTH),
        .t_job (t_job)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_rdata (w_head_job),
        .o_empty (w_q_empty)
    );

    pnrf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .t_job         (t_job)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_head  (w_head_job),
        .o_pop     (w_pop),
        .o_busy    (w_busy),
        .o_out     (o_out)
    );

    // no item gets in while the RAM is being zeroed
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !i_in.ready)
        else $error("item accepted during zeroing pass");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("queue pop while empty");

    // a drawing operation never returns data
    a_drawn_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.drawn) |-> (o_out.read_data == 8'd0))
        else $error("drawn result carries read data");
endmodule
